// ===== hdl/dcfp_pkg.sv =====
// Shared types and constants for the delimited command frame parser.
package dcfp_pkg;

    localparam int TEXT_MAX_DEFAULT = 95;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 7;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_NUM_DONE  = 2'd0;
    localparam kind_t KIND_TEXT_BYTE = 2'd1;
    localparam kind_t KIND_TEXT_DONE = 2'd2;
    localparam kind_t KIND_ABORT     = 2'd3;

    localparam logic [INDEX_W-1:0] TEXT_FIELD    = 3'd7;
    localparam logic [INDEX_W-1:0] FIRST_HEX_FLD = 3'd5;

    localparam logic [BYTE_W-1:0] CH_DATA_LO = 8'd32;
    localparam logic [BYTE_W-1:0] CH_DATA_HI = 8'd122;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_BAR     = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_X_LO    = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP    = 8'h58;

endpackage

// ===== hdl/delimited_command_frame_parser.sv =====
// Frame parser top level: input byte register, field decode, result register.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+---------------------------
//  input   | in_valid, in_ready, rx_byte               | in_valid && in_ready
//  output  | out_valid, out_ready, kind, field_index,  | out_valid && out_ready
//          | field_value, text_char, text_length,      |
//          | frame_end                                 |
//
// One byte per cycle unless a result stalls; byte register, then result register.
// Each byte is decoded combinationally; the x10 / x16 accumulate is a shift-add.
// Reset clears the parser to idle and empties both registers.
// A stalled result holds the byte register; in_ready drops only while both are full.
module delimited_command_frame_parser #(
    parameter int TEXT_MAX = dcfp_pkg::TEXT_MAX_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dcfp_pkg::BYTE_W-1:0]           rx_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dcfp_pkg::KIND_W-1:0]           kind,
    output logic [dcfp_pkg::INDEX_W-1:0]          field_index,
    output logic signed [dcfp_pkg::VALUE_W-1:0]   field_value,
    output logic [dcfp_pkg::CHAR_W-1:0]           text_char,
    output logic [dcfp_pkg::LEN_W-1:0]            text_length,
    output logic                                  frame_end
);
    import dcfp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIELD,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [INDEX_W-1:0]   field_reg, field_next;
    logic [VALUE_W-1:0]   accum_reg, accum_next;
    logic                 neg_reg, neg_next;
    logic                 started_reg, started_next;
    logic                 stopped_reg, stopped_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 zero_lead_reg, zero_lead_next;
    logic [LEN_W-1:0]     text_count_reg, text_count_next;

    logic                 stage_valid_reg;
    logic [BYTE_W-1:0]    stage_byte_reg;

    logic                 out_valid_reg;
    kind_t                kind_reg, kind_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 end_reg, end_next;
    logic                 produce;

    logic                 advance;
    logic [BYTE_W-1:0]    b;
    logic                 is_data;
    logic                 is_term;
    logic                 hex;
    logic                 digit_ok;
    logic [3:0]           digit;
    logic [VALUE_W-1:0]   accum_scaled;

    assign b        = stage_byte_reg;
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    assign is_data = (b >= CH_DATA_LO) && (b <= CH_DATA_HI);
    assign is_term = (b == CH_BAR) || (b == CH_CLOSE);
    assign hex     = (field_reg >= FIRST_HEX_FLD);

    always_comb
    begin
        digit_ok = 1'b0;
        digit    = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            digit_ok = 1'b1;
            digit    = 4'(b - 8'h30);
        end
        else if (hex && b >= 8'h61 && b <= 8'h66)
        begin
            digit_ok = 1'b1;
            digit    = 4'(b - 8'h61 + 8'd10);
        end
        else if (hex && b >= 8'h41 && b <= 8'h46)
        begin
            digit_ok = 1'b1;
            digit    = 4'(b - 8'h41 + 8'd10);
        end
    end

    assign accum_scaled = hex ? {accum_reg[VALUE_W-5:0], 4'b0000}
                              : ({accum_reg[VALUE_W-4:0], 3'b000}
                                 + {accum_reg[VALUE_W-2:0], 1'b0});

    always_comb
    begin
        state_next      = state_reg;
        field_next      = field_reg;
        accum_next      = accum_reg;
        neg_next        = neg_reg;
        started_next    = started_reg;
        stopped_next    = stopped_reg;
        digit_seen_next = digit_seen_reg;
        zero_lead_next  = zero_lead_reg;
        text_count_next = text_count_reg;
        produce         = 1'b0;
        kind_next       = KIND_ABORT;
        value_next      = '0;
        char_next       = '0;
        len_next        = '0;
        end_next        = 1'b0;

        if (b == CH_OPEN)
        begin
            state_next      = ST_FIELD;
            field_next      = '0;
            accum_next      = '0;
            neg_next        = 1'b0;
            started_next    = 1'b0;
            stopped_next    = 1'b0;
            digit_seen_next = 1'b0;
            zero_lead_next  = 1'b0;
            text_count_next = '0;
        end
        else if (state_reg == ST_FIELD)
        begin
            if (is_data)
            begin
                if (field_reg == TEXT_FIELD)
                begin
                    if (text_count_reg < LEN_W'(TEXT_MAX))
                    begin
                        text_count_next = text_count_reg + 1'b1;
                        produce         = 1'b1;
                        kind_next       = KIND_TEXT_BYTE;
                        char_next       = b[CHAR_W-1:0];
                    end
                end
                else if (!stopped_reg)
                begin
                    if (!started_reg && b == CH_SPACE)
                    begin
                        started_next = 1'b0;
                    end
                    else if (!started_reg && (b == CH_PLUS || b == CH_MINUS))
                    begin
                        started_next = 1'b1;
                        neg_next     = (b == CH_MINUS);
                    end
                    else if (hex && zero_lead_reg && (b == CH_X_LO || b == CH_X_UP))
                    begin
                        zero_lead_next = 1'b0;
                    end
                    else if (!digit_ok)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        zero_lead_next  = !digit_seen_reg && (digit == 4'd0);
                        digit_seen_next = 1'b1;
                        started_next    = 1'b1;
                        accum_next      = accum_scaled + VALUE_W'(digit);
                    end
                end
            end
            else
            begin
                produce         = 1'b1;
                accum_next      = '0;
                neg_next        = 1'b0;
                started_next    = 1'b0;
                stopped_next    = 1'b0;
                digit_seen_next = 1'b0;
                zero_lead_next  = 1'b0;
                if (is_term)
                begin
                    end_next = (b == CH_CLOSE);
                    if (field_reg == TEXT_FIELD)
                    begin
                        kind_next = KIND_TEXT_DONE;
                        len_next  = text_count_reg;
                    end
                    else
                    begin
                        kind_next  = KIND_NUM_DONE;
                        value_next = neg_reg ? (VALUE_W'(0) - accum_reg) : accum_reg;
                    end
                    if (b == CH_CLOSE)
                        state_next = ST_DONE;
                    else if (field_reg == TEXT_FIELD)
                        state_next = ST_IDLE;
                    else
                        field_next = field_reg + 1'b1;
                end
                else
                begin
                    kind_next  = KIND_ABORT;
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            field_reg       <= '0;
            accum_reg       <= '0;
            neg_reg         <= 1'b0;
            started_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            digit_seen_reg  <= 1'b0;
            zero_lead_reg   <= 1'b0;
            text_count_reg  <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
            begin
                state_reg      <= state_next;
                field_reg      <= field_next;
                accum_reg      <= accum_next;
                neg_reg        <= neg_next;
                started_reg    <= started_next;
                stopped_reg    <= stopped_next;
                digit_seen_reg <= digit_seen_next;
                zero_lead_reg  <= zero_lead_next;
                text_count_reg <= text_count_next;
                out_valid_reg  <= produce;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_byte_reg <= rx_byte;
        if (advance && produce)
        begin
            kind_reg  <= kind_next;
            index_reg <= field_reg;
            value_reg <= value_next;
            char_reg  <= char_next;
            len_reg   <= len_next;
            end_reg   <= end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign field_index = index_reg;
    assign field_value = value_reg;
    assign text_char   = char_reg;
    assign text_length = len_reg;
    assign frame_end   = end_reg;

endmodule
